// File: hw/rtl/gddr_pkg.sv
// ----------------------------------------------------------------------------
// gddr_pkg
// Shared types, constants and helper functions of the grid DDA column
// raycaster: register indexes, tile codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package gddr_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAMERA_X      = 3'd0,
        REG_CAMERA_Y      = 3'd1,
        REG_HEADING_X     = 3'd2,
        REG_HEADING_Y     = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5
    } cfg_reg_t;

    // Tile codes
    localparam logic [7:0] CODE_EMPTY = 8'h2E;
    localparam logic [7:0] CODE_WALL  = 8'h23;
    localparam logic [7:0] CODE_RED   = 8'h52;
    localparam logic [7:0] CODE_GREEN = 8'h47;
    localparam logic [7:0] CODE_BLUE  = 8'h42;

    // Fixed datapath widths
    localparam int RAY_W   = 31;  // ray component scaled by screen width
    localparam int RMAG_W  = 30;  // magnitude of a ray component
    localparam int DELTA_W = 42;  // per-axis step length, Q26.16 up to w*2^30
    localparam int FRAC_W  = 11;  // distance to first boundary, Q1.10 up to 1024
    localparam int LH_W    = 28;  // line height up to w*2^16
    localparam int DIST_W  = 24;

    localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;

    // floor(w/3) == (w*2731) >> 13 for every 12-bit w
    localparam int W_DIV3_MUL   = 2731;
    localparam int W_DIV3_SHIFT = 13;

    // Divider operand selection
    typedef enum logic [1:0] {
        DSEL_X    = 2'd0,
        DSEL_Y    = 2'd1,
        DSEL_DIST = 2'd2,
        DSEL_LH   = 2'd3
    } div_sel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     tile_write;
        logic     load_col;
        logic     setup;
        logic     div_start;
        div_sel_t div_sel;
        logic     store_dx;
        logic     store_dy;
        logic     mul_init;
        logic     mul_step;
        logic     walk_step;
        logic     walk_look;
        logic     num_load;
        logic     store_dist;
        logic     store_lh;
        logic     span_load;
        logic     out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic walk_end;
        logic out_free;
    } dp_status_t;

    // Wall colour of a tile code, halved on y-facing walls
    function automatic rgb_t tile_color(input logic [7:0] code, input logic halve);
        rgb_t c;
        case (code)
            CODE_WALL:  c = '{red: 8'd51,  green: 8'd204, blue: 8'd204};
            CODE_RED:   c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
            CODE_GREEN: c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
            CODE_BLUE:  c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
            default:    c = '{red: 8'd128, green: 8'd255, blue: 8'd128};
        endcase
        if (halve)
        begin
            c.red   = c.red >> 1;
            c.green = c.green >> 1;
            c.blue  = c.blue >> 1;
        end
        return c;
    endfunction

    // Magnitude of a signed ray component
    function automatic logic [RMAG_W-1:0] ray_mag(input logic signed [RAY_W-1:0] v);
        logic signed [RAY_W-1:0] n;
        n = -v;
        return v[RAY_W-1] ? RMAG_W'(n) : RMAG_W'(v);
    endfunction

endpackage

// File: hw/rtl/gddr_div.sv
// ----------------------------------------------------------------------------
// gddr_div
// Restoring unsigned divider, one quotient bit per cycle. Shared by the
// step length, distance and line height divisions.
// ----------------------------------------------------------------------------
module gddr_div #(
    parameter int DN = 54,
    parameter int DV = 30
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DN-1:0] dividend,
    input  logic [DV-1:0] divisor,
    output logic          done,
    output logic [DN-1:0] quotient
);
    localparam int CNT_W = $clog2(DN);

    logic [DN-1:0]    quo_reg;
    logic [DV-1:0]    rem_reg;
    logic [DV-1:0]    dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DV:0]   shifted;
    logic [DV+1:0] diff;
    logic          fits;

    // Trial subtract of the next partial remainder
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DN-1]};
        diff    = {1'b0, shifted} - {2'b0, dvs_reg};
        fits    = !diff[DV+1];
    end

    // Control: count bits, flag the end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DN - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift dividend out, quotient bits in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DN-2:0], fits};
            rem_reg <= fits ? diff[DV-1:0] : shifted[DV-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hw/rtl/gddr_dp.sv
// ----------------------------------------------------------------------------
// gddr_dp
// Raycaster datapath: configuration registers, tile map memory, ray setup,
// grid walk registers, distance and span arithmetic, output register.
// ----------------------------------------------------------------------------
module gddr_dp #(
    parameter int MAP_SIDE  = 64,
    parameter int MAX_STEPS = 500
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gddr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gddr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [10:0]                       column,
    input  logic [5:0]                        tile_x,
    input  logic [5:0]                        tile_y,
    input  logic [7:0]                        tile_code,
    input  logic                              out_stall,
    input  gddr_pkg::dp_cmd_t                 cmd,
    output gddr_pkg::dp_status_t              status,
    output logic                              out_valid,
    output logic [10:0]                       column_out,
    output logic [23:0]                       wall_distance,
    output logic [10:0]                       span_start,
    output logic [10:0]                       span_end,
    output logic [7:0]                        red,
    output logic [7:0]                        green,
    output logic [7:0]                        blue,
    output logic                              y_side,
    output logic                              step_limit_hit
);
    import gddr_pkg::*;

    localparam int DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int MXW   = $clog2(MAP_SIDE);
    localparam int MA    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAP_SIDE + MAX_STEPS + 66) + 1;
    localparam int NCW   = $clog2(MAX_STEPS + 2);
    localparam int AW    = DELTA_W + NCW + 1;
    localparam int PW    = DELTA_W + FRAC_W;
    localparam int NW    = CW + 11;
    localparam int NPW   = NW + 12;
    localparam int DN    = NPW + 20;
    localparam int MCW   = $clog2(FRAC_W);

    // Configuration registers
    logic [15:0]        cam_x_reg, cam_y_reg;
    logic signed [15:0] hdg_x_reg, hdg_y_reg;
    logic [11:0]        scr_w_reg, scr_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= 16'd1536;
            cam_y_reg <= 16'd1536;
            hdg_x_reg <= 16'sd16384;
            hdg_y_reg <= 16'sd0;
            scr_w_reg <= 12'd640;
            scr_h_reg <= 12'd480;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CAMERA_X:      cam_x_reg <= cfg_data;
                REG_CAMERA_Y:      cam_y_reg <= cfg_data;
                REG_HEADING_X:     hdg_x_reg <= $signed(cfg_data);
                REG_HEADING_Y:     hdg_y_reg <= $signed(cfg_data);
                REG_SCREEN_WIDTH:  scr_w_reg <= cfg_data[11:0];
                REG_SCREEN_HEIGHT: scr_h_reg <= cfg_data[11:0];
                default:           ;
            endcase
        end
    end

    // Per-cast registers
    logic [10:0]            col_reg;
    logic [11:0]            w_reg;
    logic [RMAG_W-1:0]      magx_reg, magy_reg;
    logic                   negx_reg, negy_reg, infx_reg, infy_reg;
    logic [FRAC_W-1:0]      fracx_reg, fracy_reg;
    logic [DELTA_W-1:0]     dx_reg, dy_reg;
    logic [PW-1:0]          px_reg, py_reg;
    logic [MCW-1:0]         mcnt_reg;
    logic [AW-1:0]          sx_reg, sy_reg;
    logic signed [CW-1:0]   cx_reg, cy_reg;
    logic                   side_reg;
    logic [NCW-1:0]         n_reg;
    logic [7:0]             rd_reg, code_reg;
    logic                   oob_reg;
    logic [NPW-1:0]         nprod_reg;
    logic [DIST_W-1:0]      dist_reg;
    logic [LH_W-1:0]        lh_reg;
    logic [10:0]            start_reg, end_reg;

    // Ray setup: ray = heading*w + plane*(2*col - w)
    logic [11:0]              w_c;
    logic signed [12:0]       w_s;
    logic signed [13:0]       off_c;
    logic signed [RAY_W-1:0]  rx_c, ry_c;

    always_comb
    begin
        w_c   = (scr_w_reg == 12'd0) ? 12'd1 : scr_w_reg;
        w_s   = $signed({1'b0, w_c});
        off_c = $signed({2'b0, col_reg, 1'b0}) - $signed({2'b0, w_c});
        rx_c  = RAY_W'(hdg_x_reg) * RAY_W'(w_s) - RAY_W'(hdg_y_reg) * RAY_W'(off_c);
        ry_c  = RAY_W'(hdg_y_reg) * RAY_W'(w_s) + RAY_W'(hdg_x_reg) * RAY_W'(off_c);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_col)
        begin
            col_reg <= column;
        end
        if (cmd.setup)
        begin
            w_reg     <= w_c;
            magx_reg  <= ray_mag(rx_c);
            magy_reg  <= ray_mag(ry_c);
            negx_reg  <= rx_c[RAY_W-1];
            negy_reg  <= ry_c[RAY_W-1];
            infx_reg  <= (rx_c == '0);
            infy_reg  <= (ry_c == '0);
            fracx_reg <= rx_c[RAY_W-1] ? {1'b0, cam_x_reg[9:0]}
                                       : FRAC_W'(1024) - {1'b0, cam_x_reg[9:0]};
            fracy_reg <= ry_c[RAY_W-1] ? {1'b0, cam_y_reg[9:0]}
                                       : FRAC_W'(1024) - {1'b0, cam_y_reg[9:0]};
        end
    end

    // Shared divider with operand selection
    logic [DN-1:0]     dvd_c, quo;
    logic [RMAG_W-1:0] dvs_c;
    logic              div_done;

    always_comb
    begin
        case (cmd.div_sel)
            DSEL_X:
            begin
                dvd_c = DN'({w_reg, 30'b0});
                dvs_c = magx_reg;
            end
            DSEL_Y:
            begin
                dvd_c = DN'({w_reg, 30'b0});
                dvs_c = magy_reg;
            end
            DSEL_DIST:
            begin
                dvd_c = {nprod_reg, 20'b0};
                dvs_c = side_reg ? magy_reg : magx_reg;
            end
            default:
            begin
                dvd_c = DN'({w_reg, 16'b0});
                dvs_c = RMAG_W'(dist_reg);
            end
        endcase
    end

    gddr_div #(
        .DN (DN),
        .DV (RMAG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd_c),
        .divisor  (dvs_c),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.store_dx)
        begin
            dx_reg <= quo[DELTA_W-1:0];
        end
        if (cmd.store_dy)
        begin
            dy_reg <= quo[DELTA_W-1:0];
        end
    end

    // First boundary distance: frac * delta, one fraction bit per cycle
    logic [PW-1:0] px_next, py_next;
    logic          mul_last;

    always_comb
    begin
        px_next  = {px_reg[PW-2:0], 1'b0}
                 + (fracx_reg[FRAC_W-1-mcnt_reg] ? PW'(dx_reg) : '0);
        py_next  = {py_reg[PW-2:0], 1'b0}
                 + (fracy_reg[FRAC_W-1-mcnt_reg] ? PW'(dy_reg) : '0);
        mul_last = (mcnt_reg == MCW'(FRAC_W - 1));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_init)
        begin
            px_reg   <= '0;
            py_reg   <= '0;
            mcnt_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            mcnt_reg <= mcnt_reg + 1'b1;
        end
    end

    // Grid walk: pick the nearer boundary, step, look up the tile
    logic                 go_x;
    logic signed [CW-1:0] nx_c, ny_c;
    logic                 inmap_c;
    logic [MA-1:0]        rd_addr, wr_addr;
    logic                 wr_ok;
    logic [7:0]           code_now;
    logic [7:0]           tile_map [DEPTH];

    always_comb
    begin
        go_x = !infx_reg && (infy_reg || (sx_reg < sy_reg));
        nx_c = cx_reg;
        ny_c = cy_reg;
        if (go_x)
        begin
            nx_c = negx_reg ? cx_reg - CW'(1) : cx_reg + CW'(1);
        end
        else
        begin
            ny_c = negy_reg ? cy_reg - CW'(1) : cy_reg + CW'(1);
        end
        inmap_c  = !nx_c[CW-1] && !ny_c[CW-1]
                 && (nx_c < $signed(CW'(MAP_SIDE))) && (ny_c < $signed(CW'(MAP_SIDE)));
        rd_addr  = MA'(ny_c[MXW-1:0]) * MA'(MAP_SIDE) + MA'(nx_c[MXW-1:0]);
        wr_ok    = (9'(tile_x) < 9'(MAP_SIDE)) && (9'(tile_y) < 9'(MAP_SIDE));
        wr_addr  = MA'(tile_y) * MA'(MAP_SIDE) + MA'(tile_x);
        code_now = oob_reg ? CODE_WALL : rd_reg;
    end

    // Tile map memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.tile_write && wr_ok)
        begin
            tile_map[wr_addr] <= tile_code;
        end
        if (cmd.walk_step)
        begin
            rd_reg  <= tile_map[rd_addr];
            oob_reg <= !inmap_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            cx_reg   <= $signed(CW'(cam_x_reg[15:10]));
            cy_reg   <= $signed(CW'(cam_y_reg[15:10]));
            side_reg <= 1'b0;
            n_reg    <= '0;
        end
        else if (cmd.walk_step)
        begin
            cx_reg   <= nx_c;
            cy_reg   <= ny_c;
            side_reg <= !go_x;
            n_reg    <= n_reg + 1'b1;
        end
        if (cmd.mul_step && mul_last)
        begin
            sx_reg <= AW'(px_next >> 10);
            sy_reg <= AW'(py_next >> 10);
        end
        else if (cmd.walk_step)
        begin
            if (go_x)
            begin
                sx_reg <= sx_reg + AW'(dx_reg);
            end
            else
            begin
                sy_reg <= sy_reg + AW'(dy_reg);
            end
        end
        if (cmd.walk_look)
        begin
            code_reg <= code_now;
        end
    end

    // Distance numerator: |boundary - camera| * w
    logic signed [CW-1:0]  ncx_c;
    logic [15:0]           ncam_c;
    logic signed [NW:0]    num_c, num_neg;
    logic [NW-1:0]         nmag_c;

    always_comb
    begin
        ncx_c   = side_reg ? cy_reg : cx_reg;
        ncam_c  = side_reg ? cam_y_reg : cam_x_reg;
        num_c   = ($signed((NW+1)'(ncx_c)) <<< 10)
                - $signed((NW+1)'(ncam_c))
                + ((side_reg ? negy_reg : negx_reg) ? (NW+1)'(1024) : '0);
        num_neg = -num_c;
        nmag_c  = num_c[NW] ? NW'(num_neg) : NW'(num_c);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.num_load)
        begin
            nprod_reg <= NPW'(nmag_c) * NPW'(w_reg);
        end
        if (cmd.store_dist)
        begin
            if ((side_reg ? infy_reg : infx_reg) || (quo[DN-1:DIST_W] != '0))
            begin
                dist_reg <= DIST_MAX;
            end
            else
            begin
                dist_reg <= quo[DIST_W-1:0];
            end
        end
        if (cmd.store_lh)
        begin
            lh_reg <= (dist_reg == '0) ? LH_W'({w_reg, 16'b0}) : quo[LH_W-1:0];
        end
    end

    // Span: horizon at w/3, clamp end to w-1, height, 2047
    logic [24:0]     w3_prod;
    logic [10:0]     w3_c;
    logic [LH_W-1:0] half_c, e0_c;
    logic [11:0]     e1_c, e2_c;
    logic [10:0]     start_c, end_c;

    always_comb
    begin
        w3_prod = 25'(w_reg) * 25'(W_DIV3_MUL);
        w3_c    = w3_prod[W_DIV3_SHIFT+10:W_DIV3_SHIFT];
        half_c  = lh_reg >> 1;
        start_c = (half_c < LH_W'(w3_c)) ? w3_c - half_c[10:0] : '0;
        e0_c    = half_c + LH_W'(w3_c);
        e1_c    = (e0_c >= LH_W'(w_reg)) ? w_reg - 12'd1 : e0_c[11:0];
        e2_c    = (e1_c > scr_h_reg) ? scr_h_reg : e1_c;
        end_c   = (e2_c > 12'd2047) ? 11'd2047 : e2_c[10:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.span_load)
        begin
            start_reg <= start_c;
            end_reg   <= end_c;
        end
    end

    // Output register
    logic  out_valid_reg;
    rgb_t  color_c;

    assign color_c = tile_color(code_reg, side_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            column_out     <= col_reg;
            wall_distance  <= dist_reg;
            span_start     <= start_reg;
            span_end       <= end_reg;
            red            <= color_c.red;
            green          <= color_c.green;
            blue           <= color_c.blue;
            y_side         <= side_reg;
            step_limit_hit <= (code_reg == CODE_EMPTY);
        end
    end

    assign out_valid = out_valid_reg;

    // Status back to the controller
    always_comb
    begin
        status.div_done = div_done;
        status.mul_done = mul_last;
        status.walk_end = (code_now != CODE_EMPTY) || (n_reg > NCW'(MAX_STEPS));
        status.out_free = !out_valid_reg || !out_stall;
    end

endmodule

// File: hw/rtl/gddr_ctrl.sv
// ----------------------------------------------------------------------------
// gddr_ctrl
// Raycaster controller: accepts transactions, sequences ray setup, the
// divisions, the grid walk, span computation and the result handoff.
// ----------------------------------------------------------------------------
module gddr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 opcode,
    input  gddr_pkg::dp_status_t status,
    output gddr_pkg::dp_cmd_t    cmd,
    output logic                 in_stall
);
    import gddr_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE  = 16'b0000_0000_0000_0001,
        S_SETUP = 16'b0000_0000_0000_0010,
        S_LX    = 16'b0000_0000_0000_0100,
        S_WX    = 16'b0000_0000_0000_1000,
        S_LY    = 16'b0000_0000_0001_0000,
        S_WY    = 16'b0000_0000_0010_0000,
        S_MUL   = 16'b0000_0000_0100_0000,
        S_STEP  = 16'b0000_0000_1000_0000,
        S_LOOK  = 16'b0000_0001_0000_0000,
        S_NUM   = 16'b0000_0010_0000_0000,
        S_LD    = 16'b0000_0100_0000_0000,
        S_WD    = 16'b0000_1000_0000_0000,
        S_LL    = 16'b0001_0000_0000_0000,
        S_WL    = 16'b0010_0000_0000_0000,
        S_SPAN  = 16'b0100_0000_0000_0000,
        S_EMIT  = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = DSEL_X;
        in_stall    = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (opcode)
                    begin
                        cmd.load_col = 1'b1;
                        state_next   = S_SETUP;
                    end
                    else
                    begin
                        cmd.tile_write = 1'b1;
                    end
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_LX;
            end
            S_LX:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WX;
            end
            S_WX:
            begin
                if (status.div_done)
                begin
                    cmd.store_dx = 1'b1;
                    state_next   = S_LY;
                end
            end
            S_LY:
            begin
                cmd.div_sel   = DSEL_Y;
                cmd.div_start = 1'b1;
                state_next    = S_WY;
            end
            S_WY:
            begin
                cmd.div_sel = DSEL_Y;
                if (status.div_done)
                begin
                    cmd.store_dy = 1'b1;
                    cmd.mul_init = 1'b1;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (status.mul_done)
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.walk_step = 1'b1;
                state_next    = S_LOOK;
            end
            S_LOOK:
            begin
                cmd.walk_look = 1'b1;
                state_next    = status.walk_end ? S_NUM : S_STEP;
            end
            S_NUM:
            begin
                cmd.num_load = 1'b1;
                state_next   = S_LD;
            end
            S_LD:
            begin
                cmd.div_sel   = DSEL_DIST;
                cmd.div_start = 1'b1;
                state_next    = S_WD;
            end
            S_WD:
            begin
                cmd.div_sel = DSEL_DIST;
                if (status.div_done)
                begin
                    cmd.store_dist = 1'b1;
                    state_next     = S_LL;
                end
            end
            S_LL:
            begin
                cmd.div_sel   = DSEL_LH;
                cmd.div_start = 1'b1;
                state_next    = S_WL;
            end
            S_WL:
            begin
                cmd.div_sel = DSEL_LH;
                if (status.div_done)
                begin
                    cmd.store_lh = 1'b1;
                    state_next   = S_SPAN;
                end
            end
            S_SPAN:
            begin
                cmd.span_load = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/grid_dda_column_raycaster.sv
// ----------------------------------------------------------------------------
// grid_dda_column_raycaster
// Tile-map raycaster: stores map tiles and casts one screen column per
// cast transaction with a DDA grid walk.
// ----------------------------------------------------------------------------
// A tile write is done in the idle state. A cast walks at most
// MAX_STEPS+1 grid cells and runs four divisions through one shared divider
// of DN = $clog2(MAP_SIDE+MAX_STEPS+66) + 44 bits (54 at the defaults),
// one bit a cycle. Each grid step has a step state and a look state for
// the registered read of the tile map. The result sits in an output
// register, so the next transaction is taken while it waits.
// ----------------------------------------------------------------------------
module grid_dda_column_raycaster #(
    parameter int MAP_SIDE  = 64,
    parameter int MAX_STEPS = 500
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gddr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gddr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            opcode,
    input  logic [10:0]                     column,
    input  logic [5:0]                      tile_x,
    input  logic [5:0]                      tile_y,
    input  logic [7:0]                      tile_code,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [10:0]                     column_out,
    output logic [23:0]                     wall_distance,
    output logic [10:0]                     span_start,
    output logic [10:0]                     span_end,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    output logic                            y_side,
    output logic                            step_limit_hit
);
    import gddr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer
    gddr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // Datapath
    gddr_dp #(
        .MAP_SIDE  (MAP_SIDE),
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .column         (column),
        .tile_x         (tile_x),
        .tile_y         (tile_y),
        .tile_code      (tile_code),
        .out_stall      (out_stall),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .column_out     (column_out),
        .wall_distance  (wall_distance),
        .span_start     (span_start),
        .span_end       (span_end),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .y_side         (y_side),
        .step_limit_hit (step_limit_hit)
    );

endmodule

// File: hw/rtl/gddr_chk.sv
// ----------------------------------------------------------------------------
// gddr_chk
// Port-level checks of the raycaster, bound to the top level.
// ----------------------------------------------------------------------------
module gddr_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        opcode,
    input logic        out_valid,
    input logic        out_stall,
    input logic [10:0] column_out,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue,
    input logic        y_side,
    input logic        step_limit_hit
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(column_out))
        else $error("stalled result changed");

    // Stall input while a cast is in flight
    a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode |=> in_stall)
        else $error("input taken right after a cast transaction");

    // Y-side walls are shaded to half intensity
    a_yside_dim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && y_side |-> red < 8'd128 && green < 8'd128 && blue < 8'd128)
        else $error("y-side colour not halved");

    // A walk ending at the step limit shows the empty tile colour
    a_limit_color: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && step_limit_hit |-> (y_side ? (red == 8'd64) : (red == 8'd128)))
        else $error("step limit result has wrong colour");

endmodule

bind grid_dda_column_raycaster gddr_chk u_gddr_chk (.*);

// File: verif/tb_grid_dda_column_raycaster.sv
// ----------------------------------------------------------------------------
// tb_grid_dda_column_raycaster
// Self-checking testbench of the grid DDA column raycaster. It fills two
// walled corner rooms of the tile map, keeps every camera inside one of
// them, runs a directed table of writes and casts, then random phases under
// several view settings, extremes included. Both sides idle and stall at
// random. Every cast result is checked field by field against a DDA walk
// computed in the testbench, the first directed cast against a fixed one.
// ----------------------------------------------------------------------------
module tb_grid_dda_column_raycaster;
    timeunit 1ns;
    timeprecision 1ps;

    import gddr_pkg::*;

    localparam int SIDE      = 64;
    localparam int STEP_CAP  = 500;
    localparam int SETTLE    = 1400;
    localparam int PHASES    = 9;
    localparam int PER_PHASE = 110;
    localparam int ROOM      = 16;
    localparam int HI_BASE   = SIDE - ROOM;

    localparam logic [15:0] CAM_LO_MAX = 16'((ROOM - 1) * 1024 - 1);
    localparam logic [15:0] CAM_HI_MIN = 16'((HI_BASE + 1) * 1024);

    typedef struct packed {
        logic [10:0] column_out;
        logic [23:0] wall_distance;
        logic [10:0] span_start;
        logic [10:0] span_end;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        y_side;
        logic        step_limit_hit;
    } column_t;

    typedef struct packed {
        logic        op;
        logic [10:0] col;
        logic [5:0]  tx;
        logic [5:0]  ty;
        logic [7:0]  code;
        logic        typed;
        column_t     want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = 1'b0;
    logic [10:0] column = '0;
    logic [5:0]  tile_x = '0;
    logic [5:0]  tile_y = '0;
    logic [7:0]  tile_code = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    column_t     got;
    logic        calm = 1'b0;

    // Model state
    logic [7:0]         tile_mem [SIDE*SIDE];
    logic [15:0]        cam_x = 16'd1536, cam_y = 16'd1536;
    logic signed [15:0] head_x = 16'sd16384, head_y = 16'sd0;
    logic [11:0]        scr_w = 12'd640, scr_h = 12'd480;

    column_t expected_columns [$];
    int      mismatches = 0;

    grid_dda_column_raycaster u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .column         (column),
        .tile_x         (tile_x),
        .tile_y         (tile_y),
        .tile_code      (tile_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .column_out     (got.column_out),
        .wall_distance  (got.wall_distance),
        .span_start     (got.span_start),
        .span_end       (got.span_end),
        .red            (got.red),
        .green          (got.green),
        .blue           (got.blue),
        .y_side         (got.y_side),
        .step_limit_hit (got.step_limit_hit)
    );

    always #2 clk = ~clk;

    // Tile lookup; cells off the map read as wall
    function automatic logic [7:0] tile_at(longint x, longint y);
        if (x < 0 || y < 0 || x >= SIDE || y >= SIDE)
            return CODE_WALL;
        return tile_mem[y*SIDE + x];
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Walk the grid for one column and build its result
    function automatic column_t cast_column(logic [10:0] col);
        longint w, off, rx, ry, dx, dy, sx, sy, fx, fy, cx, cy, num, r, wdist, lh, st, en;
        longint stx, sty;
        int n;
        bit side, infx, infy;
        logic [7:0] code;
        column_t res;
        w = (scr_w == 0) ? 1 : longint'(scr_w);
        off = 2*longint'(col) - w;
        rx = longint'(head_x)*w - longint'(head_y)*off;
        ry = longint'(head_y)*w + longint'(head_x)*off;
        infx = (rx == 0);
        infy = (ry == 0);
        dx = infx ? 0 : (w << 30) / abs64(rx);
        dy = infy ? 0 : (w << 30) / abs64(ry);
        stx = rx < 0 ? -1 : 1;
        sty = ry < 0 ? -1 : 1;
        fx = cam_x[9:0];
        fy = cam_y[9:0];
        if (stx > 0) fx = 1024 - fx;
        if (sty > 0) fy = 1024 - fy;
        sx = (fx*dx) >> 10;
        sy = (fy*dy) >> 10;
        cx = cam_x[15:10];
        cy = cam_y[15:10];
        side = 0;
        n = 0;
        while (1)
        begin
            if (!infx && (infy || sx < sy))
            begin
                sx += dx; cx += stx; side = 0;
            end
            else
            begin
                sy += dy; cy += sty; side = 1;
            end
            n++;
            code = tile_at(cx, cy);
            if (code != CODE_EMPTY || n > STEP_CAP)
                break;
        end
        if (side == 0)
        begin
            num = cx*1024 - longint'(cam_x) + (stx < 0 ? 1024 : 0);
            r = rx;
        end
        else
        begin
            num = cy*1024 - longint'(cam_y) + (sty < 0 ? 1024 : 0);
            r = ry;
        end
        if (r == 0)
            wdist = 24'hFFFFFF;
        else
        begin
            wdist = ((abs64(num)*w) << 20) / abs64(r);
            if (wdist > 24'hFFFFFF) wdist = 24'hFFFFFF;
        end
        lh = (wdist == 0) ? (w << 16) : (w << 16) / wdist;
        st = w/3 - lh/2;
        if (st < 0) st = 0;
        en = lh/2 + w/3;
        if (en >= w) en = w - 1;
        if (en > longint'(scr_h)) en = scr_h;
        if (en > 2047) en = 2047;
        case (code)
            CODE_WALL:  {res.red, res.green, res.blue} = {8'd51, 8'd204, 8'd204};
            CODE_RED:   {res.red, res.green, res.blue} = {8'd255, 8'd0, 8'd0};
            CODE_GREEN: {res.red, res.green, res.blue} = {8'd0, 8'd255, 8'd0};
            CODE_BLUE:  {res.red, res.green, res.blue} = {8'd0, 8'd0, 8'd255};
            default:    {res.red, res.green, res.blue} = {8'd128, 8'd255, 8'd128};
        endcase
        if (side)
        begin
            res.red   = res.red >> 1;
            res.green = res.green >> 1;
            res.blue  = res.blue >> 1;
        end
        res.column_out     = col;
        res.wall_distance  = wdist[23:0];
        res.span_start     = st[10:0];
        res.span_end       = en[10:0];
        res.y_side         = side;
        res.step_limit_hit = (code == CODE_EMPTY);
        return res;
    endfunction

    // Idle or stall decision at random, none while calm
    function automatic bit hold_off();
        return !calm && ($urandom_range(0, 99) < 36);
    endfunction

    // Present one transaction and update the model once it is taken
    task automatic send(row_t it);
        while (hold_off())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= it.op;
        column    <= it.col;
        tile_x    <= it.tx;
        tile_y    <= it.ty;
        tile_code <= it.code;
        do
            @(posedge clk);
        while (in_stall);
        if (!it.op)
            tile_mem[it.ty*SIDE + it.tx] = it.code;
        else if (it.typed)
            expected_columns.push_back(it.want);
        else
            expected_columns.push_back(cast_column(it.col));
    endtask

    // Wait until every result is back and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_columns.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_CAMERA_X:      cam_x = val;
            REG_CAMERA_Y:      cam_y = val;
            REG_HEADING_X:     head_x = val;
            REG_HEADING_Y:     head_y = val;
            REG_SCREEN_WIDTH:  scr_w = val[11:0];
            REG_SCREEN_HEIGHT: scr_h = val[11:0];
            default: ;
        endcase
    endtask

    task automatic set_view(logic [15:0] cx, logic [15:0] cy, logic [15:0] hx,
                            logic [15:0] hy, logic [15:0] w, logic [15:0] h);
        write_reg(REG_CAMERA_X, cx);
        write_reg(REG_CAMERA_Y, cy);
        write_reg(REG_HEADING_X, hx);
        write_reg(REG_HEADING_Y, hy);
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h7FFF;
            3: return 16'h8000;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic logic [15:0] pick12();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd4095;
            2: return 16'd1;
            default: return $urandom_range(1, 2048);
        endcase
    endfunction

    // Camera coordinate inside the low or the high corner room
    function automatic logic [15:0] pick_axis(bit upper);
        logic [15:0] lo, hi;
        lo = upper ? CAM_HI_MIN : 16'd0;
        hi = upper ? 16'hFFFF : CAM_LO_MAX;
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic row_t random_row();
        row_t it;
        bit   up;
        it = '0;
        up = 1'($urandom_range(0, 1));
        it.col = $urandom_range(0, 2047);
        it.tx  = 6'($urandom_range(0, ROOM-2)) + (up ? 6'(HI_BASE+1) : 6'd0);
        it.ty  = 6'($urandom_range(0, ROOM-2)) + (up ? 6'(HI_BASE+1) : 6'd0);
        it.op  = ($urandom_range(0, 99) < 60);
        case ($urandom_range(0, 9))
            0: it.code = CODE_WALL;
            1: it.code = CODE_RED;
            2: it.code = CODE_GREEN;
            3: it.code = CODE_BLUE;
            4: it.code = $urandom_range(0, 255);
            default: it.code = CODE_EMPTY;
        endcase
        return it;
    endfunction

    task automatic report(string field, longint want, longint seen);
        if (want != seen)
        begin
            $display("%0t %s expected %0d actual %0d", $realtime, field, want, seen);
            mismatches++;
        end
    endtask

    // Stall at random and check each result against the oldest expectation
    always @(posedge clk)
    begin
        column_t want;
        if (out_valid && !out_stall)
        begin
            if (expected_columns.size() == 0)
            begin
                $display("%0t unexpected result column %0d", $realtime, got.column_out);
                mismatches++;
            end
            else
            begin
                want = expected_columns.pop_front();
                report("column_out", want.column_out, got.column_out);
                report("wall_distance", want.wall_distance, got.wall_distance);
                report("span_start", want.span_start, got.span_start);
                report("span_end", want.span_end, got.span_end);
                report("red", want.red, got.red);
                report("green", want.green, got.green);
                report("blue", want.blue, got.blue);
                report("y_side", want.y_side, got.y_side);
                report("step_limit_hit", want.step_limit_hit, got.step_limit_hit);
            end
        end
        out_stall <= hold_off();
    end

    // Directed table under the reset view; first row expects the east wall
    row_t directed [] = '{
        '{1'b1, 11'd320, 6'd0, 6'd0, 8'd0, 1'b1,
          '{11'd320, 24'd884736, 11'd190, 11'd236, 8'd51, 8'd204, 8'd204, 1'b0, 1'b0}},
        '{1'b0, 11'd0, 6'd5, 6'd1, CODE_RED, 1'b0, '0},
        '{1'b1, 11'd320, 6'd0, 6'd0, 8'd0, 1'b0, '0},
        '{1'b0, 11'd0, 6'd1, 6'd4, CODE_GREEN, 1'b0, '0},
        '{1'b0, 11'd0, 6'd3, 6'd3, CODE_BLUE, 1'b0, '0},
        '{1'b0, 11'd0, 6'd1, 6'd0, 8'hFF, 1'b0, '0},
        '{1'b0, 11'd0, 6'd2, 6'd0, 8'h00, 1'b0, '0},
        '{1'b0, 11'd0, 6'd0, 6'd2, CODE_WALL, 1'b0, '0},
        '{1'b0, 11'd0, 6'd63, 6'd63, 8'h47, 1'b0, '0},
        '{1'b1, 11'd0, 6'd0, 6'd0, 8'd0, 1'b0, '0},
        '{1'b1, 11'd639, 6'd0, 6'd0, 8'd0, 1'b0, '0},
        '{1'b1, 11'd1, 6'd0, 6'd0, 8'd0, 1'b0, '0},
        '{1'b1, 11'd1000, 6'd0, 6'd0, 8'd0, 1'b0, '0},
        '{1'b1, 11'd2047, 6'd0, 6'd0, 8'd0, 1'b0, '0},
        '{1'b1, 11'd480, 6'd0, 6'd0, 8'd0, 1'b0, '0}
    };

    initial
    begin
        row_t it;
        int   lx, ly;
        bit   up, rim;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill two corner rooms, walled on their open sides; walks never leave them
        for (int i = 0; i < 2*ROOM*ROOM; i++)
        begin
            it = '0;
            lx = i % ROOM;
            ly = (i / ROOM) % ROOM;
            up = (i >= ROOM*ROOM);
            if (up)
            begin
                it.tx = 6'(HI_BASE + lx);
                it.ty = 6'(HI_BASE + ly);
                rim   = (lx == 0) || (ly == 0);
            end
            else
            begin
                it.tx = 6'(lx);
                it.ty = 6'(ly);
                rim   = (lx == ROOM-1) || (ly == ROOM-1);
            end
            it.code = rim ? CODE_WALL : CODE_EMPTY;
            send(it);
        end
        foreach (directed[i])
            send(directed[i]);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            calm <= (p == 2);
            case (p)
                0: set_view(16'd0, 16'd0, 16'd0, 16'd0, 16'd4095, 16'd4095);
                1: set_view(CAM_HI_MIN, 16'hFFFF, 16'h7FFF, 16'h8000, 16'd0, 16'd0);
                2: set_view(16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'd1, 16'd2048);
                3: set_view(16'd13000, 16'd9000, 16'd0, 16'd16384, 16'd640, 16'd480);
                default:
                begin
                    up = 1'($urandom_range(0, 1));
                    set_view(pick_axis(up), pick_axis(up), pick16(), pick16(),
                             pick12(), pick12());
                end
            endcase
            for (int i = 0; i < PER_PHASE; i++)
                send(random_row());
            drain();
        end

        if (mismatches == 0)
            $display("tb_grid_dda_column_raycaster OK");
        else
            $display("tb_grid_dda_column_raycaster NOT OK");
        $finish;
    end

    // Give up on a hang
    initial
    begin
        #20ms;
        $display("tb_grid_dda_column_raycaster NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/gddr_pkg.sv
hw/rtl/gddr_div.sv
hw/rtl/gddr_dp.sv
hw/rtl/gddr_ctrl.sv
hw/rtl/grid_dda_column_raycaster.sv
hw/rtl/gddr_chk.sv
verif/tb_grid_dda_column_raycaster.sv
